>>> rtl/polygon_ear_clip_triangulator_assert.svh
// Assertion macros for the ear clipping triangulator checker.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef POLYGON_EAR_CLIP_TRIANGULATOR_ASSERT_SVH
`define POLYGON_EAR_CLIP_TRIANGULATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PECT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pect checker: same-cycle property failed");

// Consequent checked in the cycle after the antecedent.
`define PECT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pect checker: next-cycle property failed");

`endif

>>> rtl/pect_pkg.sv
// Shared types, constants and helpers for the ear clipping triangulator.
// No dependencies.
package pect_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_W = 32;
    localparam int ID_W    = 16;
    localparam int NORM_W  = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ACC_W   = PROD_W + 4;
    localparam int NMUL    = 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [ID_W-1:0]           id;
    } vertex_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NEXT,
        ST_FETCH,
        ST_DIFF,
        ST_CMUL,
        ST_CSUM,
        ST_CONT,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    function automatic logic signed [COORD_W-1:0] axis_sel(input vertex_t v, input axis_t a);
        logic signed [COORD_W-1:0] r;
        begin
            case (a)
                AXIS_X:  r = v.x;
                AXIS_Y:  r = v.y;
                AXIS_Z:  r = v.z;
                default: r = v.x;
            endcase
            axis_sel = r;
        end
    endfunction

endpackage

>>> rtl/pect_cell.sv
// One vertex cell of the rotating ring: holds a vertex, loads by address,
// otherwise takes its neighbour's vertex when the ring turns. Uses pect_pkg.
module pect_cell
    import pect_pkg::*;
(
    input  logic    clk,
    input  logic    wr_en,
    input  vertex_t wr_data,
    input  logic    shift_en,
    input  vertex_t shift_data,
    output vertex_t q
);

    vertex_t q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg <= wr_data;
        end
        else if (shift_en)
        begin
            q_reg <= shift_data;
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/pect_mul4.sv
// Four registered signed multipliers shared by the orientation and
// containment tests. Uses pect_pkg.
module pect_mul4
    import pect_pkg::*;
(
    input  logic                     clk,
    input  logic signed [DIFF_W-1:0] op_a [NMUL],
    input  logic signed [DIFF_W-1:0] op_b [NMUL],
    output logic signed [PROD_W-1:0] prod [NMUL]
);

    logic signed [PROD_W-1:0] prod_reg [NMUL];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NMUL; i++)
        begin
            prod_reg[i] <= PROD_W'(op_a[i]) * PROD_W'(op_b[i]);
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/polygon_ear_clip_triangulator.sv
// Ear clipping triangulator. Vertices load one per cycle while busy is low.
// Per candidate ear: a search over the indices visited, a ring turn to fetch the
// triple, the orientation test, and for convex triples a second ring turn plus the
// containment drain; a forced ear skips from the fetch to ST_EMIT. A triangle
// strobes from ST_EMIT after its decision, a short polygon in the cycle after its
// last vertex; the receiver never stalls. Reset clears counts, mask and strobe.
module polygon_ear_clip_triangulator
    import pect_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] pos_z,
    input  logic [ID_W-1:0]           vertex_id,
    input  logic signed [NORM_W-1:0]  norm_x,
    input  logic signed [NORM_W-1:0]  norm_y,
    input  logic signed [NORM_W-1:0]  norm_z,
    input  logic                      poly_end,
    output logic                      strobe,
    output logic [ID_W-1:0]           corner_prev,
    output logic [ID_W-1:0]           corner_ear,
    output logic [ID_W-1:0]           corner_next,
    output logic                      tri_valid,
    output logic                      tri_last
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] t;
        begin
            t = CNT_W'(i) + CNT_W'(1);
            step_idx = (t >= n) ? '0 : t[IDX_W-1:0];
        end
    endfunction

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      point_count_reg, remain_reg, n_new;
    logic [IDX_W-1:0]      prev_reg, ear_reg, nxt_reg, scan_reg, k_reg;
    logic [1:0]            wrap_reg, drain_reg;
    logic                  forced_reg;
    logic [MAX_POINTS-1:0] clipped_reg;
    axis_t                 ax_u_reg, ax_v_reg;

    logic                  strobe_reg;
    logic [ID_W-1:0]       corner_prev_reg, corner_ear_reg, corner_next_reg;
    logic                  tri_valid_reg, tri_last_reg;

    logic accept, load_en, rotate_en, emit_en, short_en, convex, k_last, p0_hit;

    // ring of vertex cells
    vertex_t cell_q [MAX_POINTS];
    vertex_t wr_vertex;

    assign wr_vertex = '{x: pos_x, y: pos_y, z: pos_z, id: vertex_id};

    for (genvar g = 0; g < MAX_POINTS; g++)
    begin : g_cell
        pect_cell u_cell (
            .clk        (clk),
            .wr_en      (load_en && (point_count_reg == CNT_W'(g))),
            .wr_data    (wr_vertex),
            .shift_en   (rotate_en),
            .shift_data (cell_q[(g + 1) % MAX_POINTS]),
            .q          (cell_q[g])
        );
    end

    logic signed [COORD_W-1:0] head_u, head_v;
    assign head_u = axis_sel(cell_q[0], ax_u_reg);
    assign head_v = axis_sel(cell_q[0], ax_v_reg);

    // projection axis choice from the negated normal
    logic signed [NORM_W:0] nrm [3];
    logic [NORM_W:0]        mag [3];
    logic signed [NORM_W:0] ic;
    axis_t                  ia, ib;

    always_comb
    begin
        nrm[0] = -(NORM_W+1)'(norm_x);
        nrm[1] = -(NORM_W+1)'(norm_y);
        nrm[2] = -(NORM_W+1)'(norm_z);
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = nrm[i][NORM_W] ? (NORM_W+1)'(-nrm[i]) : (NORM_W+1)'(nrm[i]);
        end
        ia = AXIS_X;
        ib = AXIS_Y;
        ic = nrm[2];
        if (mag[0] > mag[1])
        begin
            if (mag[0] > mag[2])
            begin
                ia = AXIS_Y;
                ib = AXIS_Z;
                ic = nrm[0];
            end
        end
        else if (mag[1] > mag[2])
        begin
            ia = AXIS_Z;
            ib = AXIS_X;
            ic = nrm[1];
        end
    end

    // captured triple and geometry registers
    logic signed [COORD_W-1:0] ua_reg, va_reg, ub_reg, vb_reg, uc_reg, vc_reg;
    logic [ID_W-1:0]           ida_reg, idb_reg, idc_reg;
    logic signed [DIFF_W-1:0]  cu_au_reg, vb_va_reg, bu_au_reg, vc_va_reg;
    logic signed [DIFF_W-1:0]  bcy_reg, cbx_reg, acx_reg, acy_reg, cay_reg;
    logic signed [DIFF_W-1:0]  pcx_reg, pcy_reg;
    logic signed [ACC_W-1:0]   den_reg, al_reg, be_reg;
    logic                      den_zero_reg, den_neg_reg;
    logic                      p0_valid_reg, p1_valid_reg, p2_valid_reg, blocked_reg;

    logic signed [DIFF_W-1:0] op_a [NMUL];
    logic signed [DIFF_W-1:0] op_b [NMUL];
    logic signed [PROD_W-1:0] prod [NMUL];

    always_comb
    begin
        if (state_reg == ST_CMUL)
        begin
            op_a[0] = cu_au_reg; op_b[0] = vb_va_reg;
            op_a[1] = bu_au_reg; op_b[1] = vc_va_reg;
            op_a[2] = bcy_reg;   op_b[2] = acx_reg;
            op_a[3] = cbx_reg;   op_b[3] = acy_reg;
        end
        else
        begin
            op_a[0] = bcy_reg;   op_b[0] = pcx_reg;
            op_a[1] = cbx_reg;   op_b[1] = pcy_reg;
            op_a[2] = cay_reg;   op_b[2] = pcx_reg;
            op_a[3] = acx_reg;   op_b[3] = pcy_reg;
        end
    end

    pect_mul4 u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    logic signed [ACC_W-1:0] area_w, ga_w;
    logic                    inside_tri;

    always_comb
    begin
        area_w = ACC_W'(prod[0]) - ACC_W'(prod[1]);
        convex = (area_w > 0);
        ga_w = den_reg - al_reg - be_reg;
        if (den_neg_reg)
        begin
            inside_tri = (al_reg <= 0) && (be_reg <= 0) && (ga_w <= 0);
        end
        else
        begin
            inside_tri = (al_reg >= 0) && (be_reg >= 0) && (ga_w >= 0);
        end
    end

    // control decode
    always_comb
    begin
        n_new     = point_count_reg + CNT_W'(point_count_reg < CNT_W'(MAX_POINTS));
        accept    = start && (state_reg == ST_IDLE);
        load_en   = accept && (point_count_reg < CNT_W'(MAX_POINTS));
        short_en  = accept && poly_end && (n_new < CNT_W'(3));
        rotate_en = (state_reg == ST_FETCH) || (state_reg == ST_CONT);
        emit_en   = (state_reg == ST_EMIT);
        k_last    = (k_reg == IDX_W'(MAX_POINTS - 1));
        p0_hit    = (state_reg == ST_CONT) && (CNT_W'(k_reg) < point_count_reg)
                    && !clipped_reg[k_reg] && (k_reg != prev_reg)
                    && (k_reg != ear_reg) && (k_reg != nxt_reg);
        busy      = (state_reg != ST_IDLE);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && poly_end && (n_new >= CNT_W'(3)))
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (!clipped_reg[scan_reg])
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (k_last)
                begin
                    state_next = forced_reg ? ST_EMIT : ST_DIFF;
                end
            end
            ST_DIFF:   state_next = ST_CMUL;
            ST_CMUL:   state_next = ST_CSUM;
            ST_CSUM:   state_next = convex ? ST_CONT : ST_NEXT;
            ST_CONT:
            begin
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == 2'd2)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = blocked_reg ? ST_NEXT : ST_EMIT;
            ST_EMIT:   state_next = (remain_reg > CNT_W'(3)) ? ST_NEXT : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            point_count_reg <= '0;
            remain_reg      <= '0;
            prev_reg        <= '0;
            ear_reg         <= '0;
            nxt_reg         <= '0;
            scan_reg        <= '0;
            k_reg           <= '0;
            wrap_reg        <= '0;
            drain_reg       <= '0;
            forced_reg      <= 1'b0;
            clipped_reg     <= '0;
            p0_valid_reg    <= 1'b0;
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            blocked_reg     <= 1'b0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            strobe_reg   <= emit_en || short_en;
            p0_valid_reg <= p0_hit;
            p1_valid_reg <= p0_valid_reg;
            p2_valid_reg <= p1_valid_reg;
            if (p2_valid_reg && (den_zero_reg || inside_tri))
            begin
                blocked_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (poly_end && (n_new < CNT_W'(3)))
                        begin
                            point_count_reg <= '0;
                        end
                        else
                        begin
                            point_count_reg <= n_new;
                            if (poly_end)
                            begin
                                remain_reg  <= n_new;
                                prev_reg    <= IDX_W'(n_new - CNT_W'(1));
                                ear_reg     <= '0;
                                nxt_reg     <= '0;
                                scan_reg    <= step_idx('0, n_new);
                                wrap_reg    <= '0;
                                clipped_reg <= '0;
                            end
                        end
                    end
                end
                ST_NEXT:
                begin
                    if (clipped_reg[scan_reg])
                    begin
                        scan_reg <= step_idx(scan_reg, point_count_reg);
                    end
                    else
                    begin
                        nxt_reg    <= scan_reg;
                        k_reg      <= '0;
                        forced_reg <= (scan_reg < ear_reg) && (wrap_reg == 2'd1);
                        if (scan_reg < ear_reg)
                        begin
                            wrap_reg <= wrap_reg + 2'd1;
                        end
                    end
                end
                ST_FETCH:
                begin
                    k_reg <= k_reg + IDX_W'(1);
                end
                ST_CSUM:
                begin
                    k_reg       <= '0;
                    blocked_reg <= 1'b0;
                    if (!convex)
                    begin
                        prev_reg <= ear_reg;
                        ear_reg  <= nxt_reg;
                        scan_reg <= step_idx(nxt_reg, point_count_reg);
                    end
                end
                ST_CONT:
                begin
                    k_reg     <= k_reg + IDX_W'(1);
                    drain_reg <= '0;
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + 2'd1;
                end
                ST_DECIDE:
                begin
                    if (blocked_reg)
                    begin
                        prev_reg <= ear_reg;
                        ear_reg  <= nxt_reg;
                        scan_reg <= step_idx(nxt_reg, point_count_reg);
                    end
                end
                ST_EMIT:
                begin
                    wrap_reg   <= '0;
                    forced_reg <= 1'b0;
                    if (remain_reg > CNT_W'(3))
                    begin
                        clipped_reg[ear_reg] <= 1'b1;
                        remain_reg           <= remain_reg - CNT_W'(1);
                        ear_reg              <= nxt_reg;
                        scan_reg             <= step_idx(nxt_reg, point_count_reg);
                    end
                    else
                    begin
                        point_count_reg <= '0;
                        remain_reg      <= '0;
                        prev_reg        <= '0;
                        nxt_reg         <= '0;
                        ear_reg         <= '0;
                        clipped_reg     <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && poly_end)
        begin
            ax_u_reg <= (ic > 0) ? ib : ia;
            ax_v_reg <= (ic > 0) ? ia : ib;
        end
        if (state_reg == ST_FETCH)
        begin
            if (k_reg == prev_reg)
            begin
                ua_reg  <= head_u;
                va_reg  <= head_v;
                ida_reg <= cell_q[0].id;
            end
            if (k_reg == ear_reg)
            begin
                ub_reg  <= head_u;
                vb_reg  <= head_v;
                idb_reg <= cell_q[0].id;
            end
            if (k_reg == nxt_reg)
            begin
                uc_reg  <= head_u;
                vc_reg  <= head_v;
                idc_reg <= cell_q[0].id;
            end
        end
        if (state_reg == ST_DIFF)
        begin
            cu_au_reg <= DIFF_W'(uc_reg) - DIFF_W'(ua_reg);
            vb_va_reg <= DIFF_W'(vb_reg) - DIFF_W'(va_reg);
            bu_au_reg <= DIFF_W'(ub_reg) - DIFF_W'(ua_reg);
            vc_va_reg <= DIFF_W'(vc_reg) - DIFF_W'(va_reg);
            bcy_reg   <= DIFF_W'(vb_reg) - DIFF_W'(vc_reg);
            cbx_reg   <= DIFF_W'(uc_reg) - DIFF_W'(ub_reg);
            acx_reg   <= DIFF_W'(ua_reg) - DIFF_W'(uc_reg);
            acy_reg   <= DIFF_W'(va_reg) - DIFF_W'(vc_reg);
            cay_reg   <= DIFF_W'(vc_reg) - DIFF_W'(va_reg);
        end
        if (state_reg == ST_CSUM)
        begin
            den_reg      <= ACC_W'(prod[2]) + ACC_W'(prod[3]);
            den_zero_reg <= ((ACC_W'(prod[2]) + ACC_W'(prod[3])) == '0);
            den_neg_reg  <= ((ACC_W'(prod[2]) + ACC_W'(prod[3])) < 0);
        end
        // containment pipeline: point offsets, products, barycentric sums
        pcx_reg <= DIFF_W'(head_u) - DIFF_W'(uc_reg);
        pcy_reg <= DIFF_W'(head_v) - DIFF_W'(vc_reg);
        al_reg  <= ACC_W'(prod[0]) + ACC_W'(prod[1]);
        be_reg  <= ACC_W'(prod[2]) + ACC_W'(prod[3]);
        if (emit_en)
        begin
            corner_prev_reg <= ida_reg;
            corner_ear_reg  <= idb_reg;
            corner_next_reg <= idc_reg;
            tri_valid_reg   <= 1'b1;
            tri_last_reg    <= (remain_reg == CNT_W'(3));
        end
        else if (short_en)
        begin
            corner_prev_reg <= '0;
            corner_ear_reg  <= '0;
            corner_next_reg <= '0;
            tri_valid_reg   <= 1'b0;
            tri_last_reg    <= 1'b1;
        end
    end

    assign strobe      = strobe_reg;
    assign corner_prev = corner_prev_reg;
    assign corner_ear  = corner_ear_reg;
    assign corner_next = corner_next_reg;
    assign tri_valid   = tri_valid_reg;
    assign tri_last    = tri_last_reg;

endmodule

>>> rtl/pect_chk.sv
// Port-level checker for the ear clipping triangulator, bound to the top.
// Depends on polygon_ear_clip_triangulator_assert.svh and pect_pkg.
`include "polygon_ear_clip_triangulator_assert.svh"

module pect_chk
    import pect_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            poly_end,
    input logic            strobe,
    input logic [ID_W-1:0] corner_prev,
    input logic [ID_W-1:0] corner_ear,
    input logic [ID_W-1:0] corner_next,
    input logic            tri_valid,
    input logic            tri_last
);

    logic corners_zero;

    assign corners_zero = (corner_prev == '0) && (corner_ear == '0) && (corner_next == '0);

    // a short polygon reports a single, empty, final transaction
    `PECT_ASSERT_SAME(a_short_result, strobe && !tri_valid, tri_last && corners_zero)
    `PECT_ASSERT_SAME(a_more_pending, strobe && !tri_last, busy)
    `PECT_ASSERT_SAME(a_last_frees, strobe && tri_last, !busy)
    `PECT_ASSERT_NEXT(a_load_quiet, start && !busy && !poly_end, !strobe)

endmodule

bind polygon_ear_clip_triangulator pect_chk u_pect_chk (.*);

>>> bench/tb_polygon_ear_clip_triangulator.sv
// Self-checking bench for the ear clipping triangulator: loads random and
// directed polygons, predicts the emitted triangles and checks every strobe.
// Depends on pect_pkg and polygon_ear_clip_triangulator.
module tb_polygon_ear_clip_triangulator;
    import pect_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = MAX_POINTS_DEF;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [ID_W-1:0]           id;
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nz;
        logic                      last;
    } vtx_item_t;

    typedef struct packed {
        logic [ID_W-1:0] p;
        logic [ID_W-1:0] e;
        logic [ID_W-1:0] n;
        logic            valid;
        logic            last;
    } tri_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [ID_W-1:0] vertex_id = '0;
    logic signed [NORM_W-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
    logic poly_end = 1'b0;
    logic strobe;
    logic [ID_W-1:0] corner_prev, corner_ear, corner_next;
    logic tri_valid, tri_last;

    vtx_item_t pending_vtx[$];
    tri_t      expected_tris[$];
    int        send_idle_pct = 25;
    int        mismatches = 0;
    int        fed = 0;

    // predictor state
    logic signed [COORD_W-1:0] sx[NPTS], sy[NPTS], sz[NPTS];
    logic [ID_W-1:0] sid[NPTS];
    int stored = 0;

    always #5 clk = ~clk;

    polygon_ear_clip_triangulator i_dut (.*);

    function automatic logic signed [127:0] cross_area(logic signed [63:0] au, av, bu, bv,
                                                       cu, cv);
        logic signed [127:0] t1, t2;
        t1 = 128'(cu - au) * 128'(bv - av);
        t2 = 128'(bu - au) * 128'(cv - av);
        return t1 - t2;
    endfunction

    function automatic bit point_inside(logic signed [63:0] au, av, bu, bv, cu, cv, pu, pv);
        logic signed [127:0] den, al, be, ga;
        logic signed [63:0] bcy, cbx, acx, acy, cay, pcx, pcy;
        bcy = bv - cv; cbx = cu - bu; acx = au - cu; acy = av - cv; cay = cv - av;
        pcx = pu - cu; pcy = pv - cv;
        den = 128'(bcy) * 128'(acx) + 128'(cbx) * 128'(acy);
        if (den == 0) return 1'b1;
        al = 128'(bcy) * 128'(pcx) + 128'(cbx) * 128'(pcy);
        be = 128'(cay) * 128'(pcx) + 128'(acx) * 128'(pcy);
        ga = den - al - be;
        if (den < 0)
        begin
            al = -al; be = -be; ga = -ga;
        end
        return al >= 0 && be >= 0 && ga >= 0;
    endfunction

    task automatic triangulate(vtx_item_t it);
        logic signed [63:0] u[NPTS], v[NPTS], c[3];
        logic signed [63:0] nm[3], mg[3], ic;
        bit gone[NPTS];
        int n, ia, ib, t, left, prv, ear, nxt, wraps;
        bit ok;
        if (stored < NPTS)
        begin
            sx[stored] = it.x; sy[stored] = it.y; sz[stored] = it.z; sid[stored] = it.id;
            stored++;
        end
        if (!it.last) return;
        n = stored;
        stored = 0;
        if (n < 3)
        begin
            expected_tris.push_back('{p: '0, e: '0, n: '0, valid: 1'b0, last: 1'b1});
            return;
        end
        nm[0] = -64'(it.nx); nm[1] = -64'(it.ny); nm[2] = -64'(it.nz);
        for (int k = 0; k < 3; k++) mg[k] = nm[k] < 0 ? -nm[k] : nm[k];
        ia = 0; ib = 1; ic = nm[2];
        if (mg[0] > mg[1])
        begin
            if (mg[0] > mg[2])
            begin
                ia = 1; ib = 2; ic = nm[0];
            end
        end
        else if (mg[1] > mg[2])
        begin
            ia = 2; ib = 0; ic = nm[1];
        end
        if (ic > 0)
        begin
            t = ia; ia = ib; ib = t;
        end
        for (int k = 0; k < n; k++)
        begin
            c[0] = sx[k]; c[1] = sy[k]; c[2] = sz[k];
            u[k] = c[ia]; v[k] = c[ib]; gone[k] = 1'b0;
        end
        left = n; nxt = 0; prv = n - 1;
        while (left >= 3)
        begin
            wraps = 0;
            ear = nxt;
            forever
            begin
                nxt = ear;
                do nxt = (nxt + 1 >= n) ? 0 : nxt + 1; while (gone[nxt]);
                if (nxt < ear)
                begin
                    wraps++;
                    if (wraps == 2) break;
                end
                ok = cross_area(u[prv], v[prv], u[ear], v[ear], u[nxt], v[nxt]) > 0;
                if (ok)
                    for (int j = 0; j < n; j++)
                        if (!gone[j] && j != prv && j != ear && j != nxt &&
                            point_inside(u[prv], v[prv], u[ear], v[ear], u[nxt], v[nxt],
                                         u[j], v[j]))
                            ok = 1'b0;
                if (ok) break;
                prv = ear;
                ear = nxt;
            end
            expected_tris.push_back('{p: sid[prv], e: sid[ear], n: sid[nxt], valid: 1'b1,
                                      last: left == 3});
            gone[ear] = 1'b1;
            left--;
        end
    endtask

    // driver: hold start while the current transaction waits on busy
    always @(posedge clk)
    begin
        if (start && !busy)
            fed <= fed + 1;
        if (!(start && busy))
        begin
            if (pending_vtx.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                vtx_item_t it;
                it = pending_vtx.pop_front();
                triangulate(it);
                start <= 1'b1;
                pos_x <= it.x; pos_y <= it.y; pos_z <= it.z; vertex_id <= it.id;
                norm_x <= it.nx; norm_y <= it.ny; norm_z <= it.nz; poly_end <= it.last;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            tri_t got, want;
            got = '{p: corner_prev, e: corner_ear, n: corner_next, valid: tri_valid,
                    last: tri_last};
            if (expected_tris.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected triangle %p", got);
            end
            else
            begin
                want = expected_tris.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("triangle mismatch: expected %p, got %p",
                                                   want, got);
                end
            end
        end
    end

    function automatic vtx_item_t rand_vtx(bit last, int span);
        vtx_item_t it;
        it.x = span == 0 ? $urandom : $signed($urandom_range(2 * span)) - span;
        it.y = span == 0 ? $urandom : $signed($urandom_range(2 * span)) - span;
        it.z = span == 0 ? $urandom : $signed($urandom_range(2 * span)) - span;
        it.id = 16'($urandom);
        it.nx = 16'($urandom); it.ny = 16'($urandom); it.nz = 16'($urandom);
        it.last = last;
        return it;
    endfunction

    task automatic add_polygon(int npts, int span);
        for (int k = 0; k < npts; k++) pending_vtx.push_back(rand_vtx(k == npts - 1, span));
    endtask

    task automatic drain_phase();
        while (pending_vtx.size() > 0 || start) @(posedge clk);
        while (expected_tris.size() > 0 || busy) @(posedge clk);
    endtask

    initial
    begin
        vtx_item_t it;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // directed: short polygons, extremes, a square, every axis choice
        add_polygon(1, 0);
        add_polygon(2, 0);
        it = '{x: 32'sh7fffffff, y: 32'sh80000000, z: '0, id: 16'hffff, nx: 16'sh8000,
               ny: 16'sh7fff, nz: '0, last: 1'b0};
        pending_vtx.push_back(it);
        it.x = 32'sh80000000; it.y = 32'sh7fffffff; it.z = 32'sh7fffffff; it.id = '0;
        pending_vtx.push_back(it);
        it.x = 32'sh7fffffff; it.z = 32'sh80000000; it.id = 16'h1234; it.last = 1'b1;
        pending_vtx.push_back(it);
        for (int a = 0; a < 3; a++)
            for (int s = 0; s < 2; s++)
                for (int k = 0; k < 4; k++)
                begin
                    it = '{x: (k == 1 || k == 2) ? 65536 : 0, y: (k >= 2) ? 65536 : 0,
                           z: k * 100, id: 16'(a * 8 + s * 4 + k), nx: '0, ny: '0, nz: '0,
                           last: k == 3};
                    if (a == 0) it.nx = s ? 16'sh4000 : -16'sh4000;
                    if (a == 1) it.ny = s ? 16'sh4000 : -16'sh4000;
                    if (a == 2) it.nz = s ? 16'sh4000 : -16'sh4000;
                    pending_vtx.push_back(it);
                end
        // over-long polygon drops the tail
        add_polygon(34, 0);
        drain_phase();
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = ph == 0 ? 25 : ph == 1 ? 72 : 0;
            for (int pcount = 0; pcount < 3; pcount++)
                add_polygon($urandom_range(3, 8), ($urandom_range(3) == 0) ? 0 : 50);
            add_polygon($urandom_range(1, 2), 0);
            drain_phase();
        end
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_tris.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/pect_pkg.sv
rtl/pect_cell.sv
rtl/pect_mul4.sv
rtl/polygon_ear_clip_triangulator.sv
rtl/pect_chk.sv
bench/tb_polygon_ear_clip_triangulator.sv
